// File: rtl/core/rcw_pkg.sv
package rcw_pkg;

    localparam int SCREEN_W  = 640;
    localparam int SCREEN_H  = 480;
    localparam int TEX_W     = 64;
    localparam int TEX_H     = 64;
    localparam int FRAC_BITS = 16;

    localparam int COL_W     = 11;
    localparam int DIST_W    = 24;
    localparam int DIR_W     = 16;
    localparam int ROW_W     = 11;
    localparam int TEXC_W    = 8;
    localparam int TEXC_BITS = 6;
    localparam int SEL_W     = 3;
    localparam int CFG_IDX_W = 3;

    // line height numerator and its quotient width
    localparam int LH_W = 25;
    localparam logic [LH_W-1:0] LH_NUM = LH_W'(SCREEN_H) << FRAC_BITS;

    // texture row quotients never exceed TEX_H << FRAC_BITS
    localparam int Q2_W = 23;
    localparam logic [Q2_W-1:0] STEP_NUM = Q2_W'(TEX_H) << FRAC_BITS;

    localparam int DIV_LAT  = LH_W + 1 + Q2_W;
    localparam int TEX_LAT  = 3;
    localparam int SIDE_DLY = DIV_LAT - TEX_LAT;

    localparam logic [DIST_W-1:0] MAX24  = '1;
    localparam logic [ROW_W-1:0]  HALF_H = ROW_W'(SCREEN_H / 2);

    // hit >>> 31 then floor divide by 5 through a reciprocal
    localparam int HIT_W      = 56;
    localparam int HIT_SHIFT  = 31;
    localparam int H_W        = HIT_W - HIT_SHIFT;
    localparam int U_W        = 26;
    localparam logic [U_W-1:0] TEXC_OFF = U_W'(320 * 65536);
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 27;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(26843546);

    typedef enum logic [SEL_W-1:0] {
        TEX_NORTH = 3'd0,
        TEX_SOUTH = 3'd1,
        TEX_EAST  = 3'd2,
        TEX_WEST  = 3'd3,
        TEX_DOOR  = 3'd4
    } t_tex_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0]  span_start;
        logic [ROW_W-1:0]  span_end;
        logic [DIST_W-1:0] row_start;
        logic [DIST_W-1:0] row_step;
        logic              zero_height;
    } t_div_res;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [TEXC_W-1:0] texc;
        t_tex_sel          sel;
    } t_side;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [LH_W:0] div_step(input logic [LH_W-1:0] rem,
                                               input logic            b,
                                               input logic [LH_W-1:0] d);
        logic [LH_W:0] trial;
        logic [LH_W:0] diff;
        trial = {rem, b};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            return {1'b1, diff[LH_W-1:0]};
        end else begin
            return {1'b0, trial[LH_W-1:0]};
        end
    endfunction

endpackage

// File: rtl/core/rcw_in_if.sv
interface rcw_in_if import rcw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  column;
    logic [DIST_W-1:0] perp_distance;
    logic              wall_side;
    logic              door_hit;

    modport source (output valid, column, perp_distance, wall_side, door_hit, input ready);
    modport sink   (input valid, column, perp_distance, wall_side, door_hit, output ready);
endinterface

// File: rtl/core/rcw_out_if.sv
interface rcw_out_if import rcw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  span_start;
    logic [ROW_W-1:0]  span_end;
    logic [TEXC_W-1:0] tex_column;
    logic [SEL_W-1:0]  tex_select;
    logic [DIST_W-1:0] tex_row_start;
    logic [DIST_W-1:0] tex_row_step;
    logic              zero_height;

    modport source (output valid, out_column, span_start, span_end, tex_column, tex_select,
                    tex_row_start, tex_row_step, zero_height, input ready);
    modport sink   (input valid, out_column, span_start, span_end, tex_column, tex_select,
                    tex_row_start, tex_row_step, zero_height, output ready);
endinterface

// File: rtl/core/raycast_wall_column_setup_unit.sv
// Wall column setup: one column item accepted per clock while the output is taken. The
// pipeline depth is set by two bit-per-stage dividers in series (line height, then texture rows).
// All stages advance together; when the output item is not taken the whole pipeline holds.
// Registers are per-frame and must only be written while no item is in flight.
module raycast_wall_column_setup_unit import rcw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIST_W-1:0]    i_cfg_data,
    rcw_in_if.sink               i_in,
    rcw_out_if.source            o_out
);

    logic [DIST_W-1:0] r_pos_x, r_pos_y;
    logic [DIR_W-1:0]  r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= DIR_W'(16384);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= DIR_W'(10813);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[DIR_W-1:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[DIR_W-1:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_vld [DIV_LAT+1];
    logic r_out_vld;

    assign w_en        = !r_out_vld || o_out.ready;
    assign i_in.ready  = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k <= DIV_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[DIV_LAT];
        end
    end

    // input stage
    logic [COL_W-1:0]  r_a_col;
    logic [DIST_W-1:0] r_a_perp;
    logic              r_a_side, r_a_door;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_col  <= i_in.column;
            r_a_perp <= i_in.perp_distance;
            r_a_side <= i_in.wall_side;
            r_a_door <= i_in.door_hit;
        end
    end

    t_div_res w_div;

    rcw_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_den ((r_a_perp == '0) ? DIST_W'(1) : r_a_perp),
        .o_res (w_div)
    );

    // ray direction numerators, scaled by SCREEN_W
    logic signed [12:0] w_cam;
    logic signed [29:0] r_b_nx, r_b_ny;
    logic [26:0]        r_b_base5;
    logic [DIST_W-1:0]  r_b_perp;
    logic [COL_W-1:0]   r_b_col;
    logic               r_b_side, r_b_door;

    assign w_cam = $signed({1'b0, r_a_col, 1'b0}) - 13'sd640;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_nx    <= $signed(r_dir_x) * 30'sd640 + $signed(r_plane_x) * w_cam;
            r_b_ny    <= $signed(r_dir_y) * 30'sd640 + $signed(r_plane_y) * w_cam;
            r_b_base5 <= 27'(r_a_side ? r_pos_x : r_pos_y) * 27'd5;
            r_b_perp  <= r_a_perp;
            r_b_col   <= r_a_col;
            r_b_side  <= r_a_side;
            r_b_door  <= r_a_door;
        end
    end

    // wall hit coordinate, floored to units of 2^31
    logic signed [29:0]      w_n;
    logic signed [HIT_W-1:0] w_hit;
    logic signed [H_W-1:0]   r_c_h;
    logic                    r_c_mirror;
    t_tex_sel                r_c_sel;
    logic [COL_W-1:0]        r_c_col;

    assign w_n   = r_b_side ? r_b_nx : r_b_ny;
    assign w_hit = $signed({1'b0, r_b_perp}) * w_n
                   + $signed(HIT_W'({r_b_base5, 21'b0}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_h      <= w_hit[HIT_W-1:HIT_SHIFT];
            r_c_mirror <= r_b_side ? r_b_ny[29] : (!r_b_nx[29] && r_b_nx != '0);
            r_c_col    <= r_b_col;
            if (r_b_door) begin
                r_c_sel <= TEX_DOOR;
            end else if (!r_b_side) begin
                r_c_sel <= r_b_nx[29] ? TEX_NORTH : TEX_SOUTH;
            end else begin
                r_c_sel <= r_b_ny[29] ? TEX_WEST : TEX_EAST;
            end
        end
    end

    // floor divide by 5 modulo TEX_W; offset keeps the value positive
    logic [U_W-1:0]         w_u;
    logic [U_W+RECIP_W-1:0] w_prod;
    logic [TEXC_BITS-1:0]   w_q;
    t_side                  r_d;
    t_side                  r_dl [SIDE_DLY];

    assign w_u    = {r_c_h[H_W-1], r_c_h} + TEXC_OFF;
    assign w_prod = w_u * RECIP;
    assign w_q    = w_prod[RECIP_SHIFT +: TEXC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d.col  <= r_c_col;
            r_d.sel  <= r_c_sel;
            r_d.texc <= TEXC_W'(r_c_mirror ? TEXC_BITS'(TEX_W - 1) - w_q : w_q);
            r_dl[0]  <= r_d;
            for (int k = 1; k < SIDE_DLY; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    t_side    r_out_side;
    t_div_res r_out_div;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_side <= r_dl[SIDE_DLY-1];
            r_out_div  <= w_div;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_column    = r_out_side.col;
    assign o_out.tex_column    = r_out_side.texc;
    assign o_out.tex_select    = r_out_side.sel;
    assign o_out.span_start    = r_out_div.span_start;
    assign o_out.span_end      = r_out_div.span_end;
    assign o_out.tex_row_start = r_out_div.row_start;
    assign o_out.tex_row_step  = r_out_div.row_step;
    assign o_out.zero_height   = r_out_div.zero_height;

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_height |-> o_out.tex_row_step == MAX24
                                             && o_out.tex_row_start == '0)
        else $error("zero height item without saturated step");

    a_span_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.span_start <= HALF_H && o_out.span_end >= HALF_H)
        else $error("span does not straddle the horizon");

    a_texc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.tex_column < TEXC_W'(TEX_W))
        else $error("texture column out of range");

endmodule

// File: rtl/core/rcw_div.sv
module rcw_div import rcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIST_W-1:0] i_den,
    output t_div_res          o_res
);

    // line height divider, one quotient bit per stage
    logic [LH_W-1:0]   r1_rem [LH_W];
    logic [LH_W-1:0]   r1_q   [LH_W];
    logic [DIST_W-1:0] r1_d   [LH_W];
    logic [LH_W:0]     s1     [LH_W];

    always_comb begin
        s1[0] = div_step('0, LH_NUM[LH_W-1], {1'b0, i_den});
        for (int k = 1; k < LH_W; k++) begin
            s1[k] = div_step(r1_rem[k-1], LH_NUM[LH_W-1-k], {1'b0, r1_d[k-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rem[0] <= s1[0][LH_W-1:0];
            r1_d[0]   <= i_den;
            r1_q[0]   <= LH_W'(s1[0][LH_W]);
            for (int k = 1; k < LH_W; k++) begin
                r1_rem[k] <= s1[k][LH_W-1:0];
                r1_d[k]   <= r1_d[k-1];
                r1_q[k]   <= {r1_q[k-1][LH_W-2:0], s1[k][LH_W]};
            end
        end
    end

    // span stage
    logic [LH_W-1:0]   w_lh;
    logic [DIST_W-1:0] w_half;
    logic              w_big;
    logic [LH_W-1:0]   r_s_lh;
    logic [ROW_W-1:0]  r_s_start;
    logic [ROW_W-1:0]  r_s_end;
    logic [DIST_W-1:0] r_s_td;
    logic              r_s_zh;

    assign w_lh   = r1_q[LH_W-1];
    assign w_half = w_lh[LH_W-1:1];
    assign w_big  = w_half >= DIST_W'(SCREEN_H / 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_lh    <= w_lh;
            r_s_zh    <= (w_lh == '0);
            r_s_start <= w_big ? '0 : HALF_H - w_half[ROW_W-1:0];
            r_s_end   <= w_big ? ROW_W'(SCREEN_H - 1) : HALF_H + w_half[ROW_W-1:0];
            r_s_td    <= w_big ? w_half - DIST_W'(SCREEN_H / 2) : '0;
        end
    end

    // texture row dividers, step and start side by side
    logic [LH_W-1:0]  r2a_rem [Q2_W];
    logic [Q2_W-1:0]  r2a_q   [Q2_W];
    logic [LH_W-1:0]  r2b_rem [Q2_W];
    logic [Q2_W-1:0]  r2b_q   [Q2_W];
    logic [LH_W-1:0]  r2_lh   [Q2_W];
    logic [ROW_W-1:0] r2_start [Q2_W];
    logic [ROW_W-1:0] r2_end   [Q2_W];
    logic             r2_zh    [Q2_W];
    logic [LH_W:0]    s2a [Q2_W];
    logic [LH_W:0]    s2b [Q2_W];

    always_comb begin
        s2a[0] = div_step('0, STEP_NUM[Q2_W-1], r_s_lh);
        // td << 16+6: upper bits seed the remainder
        s2b[0] = div_step(LH_W'(r_s_td[DIST_W-1:1]), r_s_td[0], r_s_lh);
        for (int j = 1; j < Q2_W; j++) begin
            s2a[j] = div_step(r2a_rem[j-1], STEP_NUM[Q2_W-1-j], r2_lh[j-1]);
            s2b[j] = div_step(r2b_rem[j-1], 1'b0, r2_lh[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2a_rem[0]  <= s2a[0][LH_W-1:0];
            r2a_q[0]    <= Q2_W'(s2a[0][LH_W]);
            r2b_rem[0]  <= s2b[0][LH_W-1:0];
            r2b_q[0]    <= Q2_W'(s2b[0][LH_W]);
            r2_lh[0]    <= r_s_lh;
            r2_start[0] <= r_s_start;
            r2_end[0]   <= r_s_end;
            r2_zh[0]    <= r_s_zh;
            for (int j = 1; j < Q2_W; j++) begin
                r2a_rem[j]  <= s2a[j][LH_W-1:0];
                r2a_q[j]    <= {r2a_q[j-1][Q2_W-2:0], s2a[j][LH_W]};
                r2b_rem[j]  <= s2b[j][LH_W-1:0];
                r2b_q[j]    <= {r2b_q[j-1][Q2_W-2:0], s2b[j][LH_W]};
                r2_lh[j]    <= r2_lh[j-1];
                r2_start[j] <= r2_start[j-1];
                r2_end[j]   <= r2_end[j-1];
                r2_zh[j]    <= r2_zh[j-1];
            end
        end
    end

    assign o_res.span_start  = r2_start[Q2_W-1];
    assign o_res.span_end    = r2_end[Q2_W-1];
    assign o_res.zero_height = r2_zh[Q2_W-1];
    assign o_res.row_step    = r2_zh[Q2_W-1] ? MAX24 : DIST_W'(r2a_q[Q2_W-1]);
    assign o_res.row_start   = r2_zh[Q2_W-1] ? '0 : DIST_W'(r2b_q[Q2_W-1]);

endmodule
